@@ sv/iwfs_pkg.sv @@
// ----------------------------------------------------------------------------
// iwfs_pkg
// Types, constants and codes shared by the isometric wireframe segment block.
// ----------------------------------------------------------------------------
package iwfs_pkg;

  localparam int MAX_COLS_DEF = 1024;

  // apb register map, register i at byte address 4*i
  localparam int PADDR_W = 5;
  localparam logic [2:0] REG_ZOOM       = 3'd0;
  localparam logic [2:0] REG_DEPTH      = 3'd1;
  localparam logic [2:0] REG_OFFSET_X   = 3'd2;
  localparam logic [2:0] REG_OFFSET_Y   = 3'd3;
  localparam logic [2:0] REG_ROW_LENGTH = 3'd4;

  localparam logic [15:0] ZOOM_RST       = 16'd2560;
  localparam logic [15:0] DEPTH_RST      = 16'd256;
  localparam logic [10:0] ROW_LENGTH_RST = 11'd1;

  // projection constants, unsigned q0.16
  localparam logic [15:0] K_C1 = 16'd46341;
  localparam logic [15:0] K_C2 = 16'd53510;
  localparam logic [15:0] K_C3 = 16'd26755;

  localparam logic [23:0] COLOR_FLAT   = 24'h80ccff;
  localparam logic [23:0] COLOR_RAISED = 24'h00b33c;
  localparam logic [23:0] COLOR_LOW_H  = 24'h994d00;
  localparam logic [23:0] COLOR_LOW_V  = 24'h000000;

  typedef struct packed {
    logic [9:0]         col;
    logic [9:0]         row;
    logic signed [15:0] height;
    logic               has_color;
    logic [23:0]        point_color;
  } pt_t;

  typedef struct packed {
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic [23:0]        seg_color;
    logic               vertical;
    logic               last;
  } seg_t;

  typedef struct packed {
    logic [15:0]        zoom;
    logic [15:0]        depth_scale;
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic [10:0]        row_length;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] y;
    logic signed [15:0] x;
  } xy_t;

  typedef struct packed {
    logic               has_color;
    logic [23:0]        color;
    logic signed [15:0] height;
  } attr_t;

  typedef struct packed {
    attr_t attrs;
    xy_t   xy;
  } row_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_SUM,
    ST_SAT,
    ST_EMIT_H,
    ST_EMIT_V,
    ST_COMMIT
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic sum;
    logic sat;
    logic sel_up;
    logic last;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic skip;
    logic has_left;
    logic has_up;
  } dp_status_t;

endpackage

@@ sv/iwfs_ram.sv @@
// ----------------------------------------------------------------------------
// iwfs_ram
// Generic single write port, single read port ram with registered read.
// ----------------------------------------------------------------------------
module iwfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/iwfs_regs.sv @@
// ----------------------------------------------------------------------------
// iwfs_regs
// APB register file holding the projection and grid settings.
// ----------------------------------------------------------------------------
module iwfs_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [iwfs_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output iwfs_pkg::cfg_t              cfg
);

  import iwfs_pkg::*;

  logic       wr;
  logic [2:0] idx;

  assign wr  = psel & penable & pwrite;
  assign idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.zoom        <= ZOOM_RST;
      cfg.depth_scale <= DEPTH_RST;
      cfg.offset_x    <= '0;
      cfg.offset_y    <= '0;
      cfg.row_length  <= ROW_LENGTH_RST;
    end else if (wr) begin
      unique case (idx)
        REG_ZOOM:       cfg.zoom        <= pwdata[15:0];
        REG_DEPTH:      cfg.depth_scale <= pwdata[15:0];
        REG_OFFSET_X:   cfg.offset_x    <= pwdata[15:0];
        REG_OFFSET_Y:   cfg.offset_y    <= pwdata[15:0];
        REG_ROW_LENGTH: cfg.row_length  <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ZOOM:       prdata = {16'b0, cfg.zoom};
      REG_DEPTH:      prdata = {16'b0, cfg.depth_scale};
      REG_OFFSET_X:   prdata = {16'b0, cfg.offset_x};
      REG_OFFSET_Y:   prdata = {16'b0, cfg.offset_y};
      REG_ROW_LENGTH: prdata = {21'b0, cfg.row_length};
      default:        prdata = '0;
    endcase
  end

endmodule

@@ sv/iwfs_ctrl.sv @@
// ----------------------------------------------------------------------------
// iwfs_ctrl
// Sequencer: accepts a point, drops one past the row length, else steps
// the projection, emits up to two segments and commits it to the line buffer.
// ----------------------------------------------------------------------------
module iwfs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pt_valid,
  output logic                 pt_ready,
  output logic                 seg_valid,
  input  logic                 seg_ready,
  input  iwfs_pkg::dp_status_t status,
  output iwfs_pkg::dp_cmd_t    cmd
);

  import iwfs_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (pt_valid && !status.skip) begin
          state_next = ST_MUL1;
        end
      end
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_SUM;
      ST_SUM:  state_next = ST_SAT;
      ST_SAT: begin
        if (status.has_left) begin
          state_next = ST_EMIT_H;
        end else if (status.has_up) begin
          state_next = ST_EMIT_V;
        end else begin
          state_next = ST_COMMIT;
        end
      end
      ST_EMIT_H: begin
        if (seg_ready) begin
          state_next = status.has_up ? ST_EMIT_V : ST_COMMIT;
        end
      end
      ST_EMIT_V: begin
        if (seg_ready) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pt_ready   = 1'b0;
    seg_valid  = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        // no point is taken while reset is held
        pt_ready = ~rst;
        cmd.load = pt_valid & ~status.skip & ~rst;
      end
      ST_MUL1: cmd.mul1 = 1'b1;
      ST_MUL2: cmd.mul2 = 1'b1;
      ST_SUM:  cmd.sum  = 1'b1;
      ST_SAT:  cmd.sat  = 1'b1;
      ST_EMIT_H: begin
        seg_valid = 1'b1;
        cmd.last  = ~status.has_up;
      end
      ST_EMIT_V: begin
        seg_valid  = 1'b1;
        cmd.sel_up = 1'b1;
        cmd.last   = 1'b1;
      end
      ST_COMMIT: cmd.commit = 1'b1;
      default: ;
    endcase
  end

endmodule

@@ sv/iwfs_dp.sv @@
// ----------------------------------------------------------------------------
// iwfs_dp
// Projection datapath, line buffer of the previous row, left neighbor
// registers and segment assembly.
// ----------------------------------------------------------------------------
module iwfs_dp #(
  parameter int MAX_COLS = iwfs_pkg::MAX_COLS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  iwfs_pkg::cfg_t        cfg,
  input  iwfs_pkg::pt_t         pt,
  input  iwfs_pkg::dp_cmd_t     cmd,
  output iwfs_pkg::dp_status_t  status,
  output iwfs_pkg::seg_t        seg
);

  import iwfs_pkg::*;

  localparam int AW = $clog2(MAX_COLS);
  localparam int LW = ($clog2(MAX_COLS + 1) > 11) ? $clog2(MAX_COLS + 1) : 11;

  // truncate toward zero from 2^-24 units, then clamp to 16 bits
  function automatic logic signed [15:0] to_screen(input logic signed [51:0] v);
    logic signed [51:0] biased;
    logic signed [27:0] q;
    logic signed [15:0] r;
    biased = v + (v[51] ? 52'sd16777215 : 52'sd0);
    q      = 28'(biased >>> 24);
    if (q > 28'sd32767) begin
      r = 16'sh7fff;
    end else if (q < -28'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = q[15:0];
    end
    return r;
  endfunction

  function automatic logic [23:0] pick_color(input attr_t a, input attr_t b,
                                             input logic [23:0] low_color);
    logic [23:0] c;
    if (a.has_color && b.has_color) begin
      c = a.color;
    end else if (a.height == 16'sd0) begin
      c = COLOR_FLAT;
    end else if (a.height > 16'sd0 || b.height > 16'sd0) begin
      c = COLOR_RAISED;
    end else begin
      c = low_color;
    end
    return c;
  endfunction

  // row length bounds check on the offered point
  logic [LW-1:0] len_raw, len_eff, col_ext;

  always_comb begin
    len_raw = LW'(cfg.row_length);
    col_ext = LW'(pt.col);
    if (len_raw == '0) begin
      len_eff = LW'(1);
    end else if (len_raw > LW'(MAX_COLS)) begin
      len_eff = LW'(MAX_COLS);
    end else begin
      len_eff = len_raw;
    end
  end

  assign status.skip = (col_ext >= len_eff);

  pt_t                p;
  logic signed [10:0] diff;
  logic [10:0]        csum;
  logic [31:0]        kx, kh;
  logic [30:0]        ky;
  logic signed [43:0] mx;
  logic [41:0]        my;
  logic signed [48:0] mh;
  logic signed [51:0] sx_sum, sy_sum;
  xy_t                here;
  xy_t                left_point;
  attr_t              left_attrs;
  attr_t              cur_attrs;
  row_entry_t         upper;
  row_entry_t         wr_entry;

  assign cur_attrs.has_color = p.has_color;
  assign cur_attrs.color     = p.point_color;
  assign cur_attrs.height    = p.height;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p    <= pt;
      diff <= $signed({1'b0, pt.col}) - $signed({1'b0, pt.row});
      csum <= {1'b0, pt.col} + {1'b0, pt.row};
    end
    if (cmd.mul1) begin
      kx <= 32'(K_C1) * 32'(cfg.zoom);
      ky <= 31'(32'(K_C3) * 32'(cfg.zoom));
      kh <= 32'(K_C2) * 32'(cfg.depth_scale);
    end
    if (cmd.mul2) begin
      mx <= $signed({1'b0, kx}) * diff;
      my <= ky * csum;
      mh <= $signed({1'b0, kh}) * $signed(p.height);
    end
    if (cmd.sum) begin
      sx_sum <= {{8{mx[43]}}, mx} + {{12{cfg.offset_x[15]}}, cfg.offset_x, 24'b0};
      sy_sum <= $signed({10'b0, my}) - {{3{mh[48]}}, mh}
              + {{12{cfg.offset_y[15]}}, cfg.offset_y, 24'b0};
    end
    if (cmd.sat) begin
      here.x <= to_screen(sx_sum);
      here.y <= to_screen(sy_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_point <= '0;
      left_attrs <= '0;
    end else if (cmd.commit) begin
      left_point <= here;
      left_attrs <= cur_attrs;
    end
  end

  assign wr_entry.attrs = cur_attrs;
  assign wr_entry.xy    = here;

  // read at accept so the upper entry is ready long before the vertical beat
  iwfs_ram #(
    .WIDTH ($bits(row_entry_t)),
    .DEPTH (MAX_COLS)
  ) u_line_buf (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (AW'(p.col)),
    .wdata (wr_entry),
    .re    (cmd.load),
    .raddr (AW'(pt.col)),
    .rdata (upper)
  );

  assign status.has_left = (p.col != '0);
  assign status.has_up   = (p.row != '0);

  xy_t   nb_xy;
  attr_t nb_attrs;

  assign nb_xy    = cmd.sel_up ? upper.xy : left_point;
  assign nb_attrs = cmd.sel_up ? upper.attrs : left_attrs;

  assign seg.start_x   = nb_xy.x;
  assign seg.start_y   = nb_xy.y;
  assign seg.end_x     = here.x;
  assign seg.end_y     = here.y;
  assign seg.seg_color = pick_color(nb_attrs, cur_attrs,
                                    cmd.sel_up ? COLOR_LOW_V : COLOR_LOW_H);
  assign seg.vertical  = cmd.sel_up;
  assign seg.last      = cmd.last;

endmodule

@@ sv/isometric_wireframe_segments_core.sv @@
// ----------------------------------------------------------------------------
// isometric_wireframe_segments_core
// Projects height-map grid points isometrically and emits the wireframe
// segments to each point's left and upper neighbors.
//
//   channel  direction  handshake                      payload
//   pt       in         pt_valid / pt_ready            iwfs_pkg::pt_t
//   seg      out        seg_valid / seg_ready          iwfs_pkg::seg_t
//   apb      in/out     psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// one point at a time: accept, two multiply steps, sum, truncate and
// clamp, a beat per segment, then a write-back into the line buffer ram;
// a point beyond the row length is accepted and dropped without these steps
// a low seg_ready holds the pending segment beat and the point behind it
// reset clears the sequencer, settings and left neighbor; the line buffer
// keeps its contents and needs no clearing pass
// ----------------------------------------------------------------------------
module isometric_wireframe_segments_core #(
  parameter int MAX_COLS = iwfs_pkg::MAX_COLS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [iwfs_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         pt_valid,
  output logic                         pt_ready,
  input  iwfs_pkg::pt_t                pt,
  output logic                         seg_valid,
  input  logic                         seg_ready,
  output iwfs_pkg::seg_t               seg
);

  import iwfs_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  assign pready = 1'b1;

  iwfs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  iwfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .pt_valid  (pt_valid),
    .pt_ready  (pt_ready),
    .seg_valid (seg_valid),
    .seg_ready (seg_ready),
    .status    (status),
    .cmd       (cmd)
  );

  iwfs_dp #(
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .pt     (pt),
    .cmd    (cmd),
    .status (status),
    .seg    (seg)
  );

endmodule
